>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the escape sequence parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AESP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AESP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/aesp_pkg.sv
// ----------------------------------------------------------------------------
// Escape sequence parser package
// Sizes, byte codes, parser modes and the result record.
// ----------------------------------------------------------------------------
package aesp_pkg;

    localparam int ARG_DEPTH = 16;
    localparam int IDX_W     = (ARG_DEPTH > 1) ? $clog2(ARG_DEPTH) : 1;
    localparam int FILL_W    = $clog2(ARG_DEPTH + 1);
    localparam int COUNT_W   = 5;
    localparam int KIND_W    = 2;
    localparam int MODE_W    = 3;
    localparam int TDATA_W   = 56;

    localparam logic [7:0] ESC_BYTE  = 8'd27;
    localparam logic [7:0] CHAR_M    = 8'h4D;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] SEP_RESET = 8'd59;

    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MOUSE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ESCAPE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INIT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MBTN    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MX      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MY      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_EMIT_RD = 3'd6;
    localparam logic [MODE_W-1:0] MODE_EMIT_WR = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [7:0]         char_value;
        logic               meta_flag;
        logic [7:0]         initiator_byte;
        logic [7:0]         arg_byte;
        logic [COUNT_W-1:0] arg_count;
        logic               arg_overflow;
        logic [7:0]         button_byte;
        logic [7:0]         mouse_x;
        logic [7:0]         mouse_y;
        logic               last;
    } out_item_t;

endpackage

>>> sv/ansi_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// ANSI escape sequence parser
// Splits a terminal byte stream into plain characters, control sequences
// (one result per stored argument byte, or one if none) and X10 mouse reports.
// ----------------------------------------------------------------------------
//  Channel   Dir  Request carries
//  s_*       in   one terminal byte
//  m_*       out  one token result (kind in tuser, end of run in tlast)
//  cfg_*     in   separator byte
//
// A byte is taken when the output register can take its result.
// A control sequence with stored arguments then runs through them in
// order: read the argument buffer entry, then load the output, per entry.
// During the run no byte is taken. A stalled output holds the result and
// blocks bytes until the register frees. aresetn clears all control state.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser
    import aesp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] char_value, [8] meta_flag, [16:9] initiator_byte, [24:17] arg_byte,
    // [29:25] arg_count, [30] arg_overflow, [38:31] button_byte,
    // [46:39] mouse_x, [54:47] mouse_y, [55] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]  m_tuser,   // [1:0] token_kind
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data   // [7:0] separator_char
);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              meta_reg, meta_next;
    logic [7:0]        init_reg, init_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              drop_reg, drop_next;
    logic [7:0]        btn_reg, btn_next;
    logic [7:0]        xpos_reg, xpos_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [7:0]        sep_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [7:0] arg_mem [ARG_DEPTH];
    logic [7:0] rd_data_reg;
    logic       mem_we;

    logic       out_free;
    logic       in_acc;
    logic       emitting;
    logic       is_arg;
    logic       run_last;
    out_item_t  seq_item;

    assign out_free  = !out_valid_reg || m_tready;
    assign emitting  = (mode_reg == MODE_EMIT_RD) || (mode_reg == MODE_EMIT_WR);
    assign s_tready  = !emitting && out_free;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign is_arg   = (s_tdata inside {[CHAR_0:CHAR_9]}) || (s_tdata == sep_reg);
    assign run_last = (FILL_W'(rd_idx_reg) + FILL_W'(1)) == fill_reg;

    // Fields common to every result of a control sequence.
    always_comb begin
        seq_item                = '0;
        seq_item.token_kind     = KIND_SEQ;
        seq_item.meta_flag      = meta_reg;
        seq_item.initiator_byte = init_reg;
        seq_item.arg_count      = COUNT_W'(fill_reg);
        seq_item.arg_overflow   = drop_reg;
    end

    always_comb begin
        mode_next      = mode_reg;
        meta_next      = meta_reg;
        init_next      = init_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        btn_next       = btn_reg;
        xpos_next      = xpos_reg;
        cmd_next       = cmd_reg;
        rd_idx_next    = rd_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;

        case (mode_reg)
            MODE_ESCAPE: begin
                if (in_acc) begin
                    if (s_tdata == ESC_BYTE) begin
                        meta_next = 1'b1;
                    end else begin
                        init_next = s_tdata;
                        mode_next = MODE_INIT;
                    end
                end
            end
            MODE_INIT: begin
                if (in_acc) begin
                    if (s_tdata == CHAR_M) begin
                        mode_next = MODE_MBTN;
                    end else if (is_arg) begin
                        if (fill_reg < FILL_W'(ARG_DEPTH)) begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end else begin
                            drop_next = 1'b1;
                        end
                    end else if (fill_reg == '0) begin
                        out_next            = seq_item;
                        out_next.char_value = s_tdata;
                        out_next.last       = 1'b1;
                        out_valid_next      = 1'b1;
                        mode_next           = MODE_NORMAL;
                    end else begin
                        cmd_next    = s_tdata;
                        rd_idx_next = '0;
                        mode_next   = MODE_EMIT_RD;
                    end
                end
            end
            MODE_MBTN: begin
                if (in_acc) begin
                    btn_next  = s_tdata;
                    mode_next = MODE_MX;
                end
            end
            MODE_MX: begin
                if (in_acc) begin
                    xpos_next = s_tdata;
                    mode_next = MODE_MY;
                end
            end
            MODE_MY: begin
                if (in_acc) begin
                    out_next             = '0;
                    out_next.token_kind  = KIND_MOUSE;
                    out_next.button_byte = btn_reg;
                    out_next.mouse_x     = xpos_reg;
                    out_next.mouse_y     = s_tdata;
                    out_next.last        = 1'b1;
                    out_valid_next       = 1'b1;
                    mode_next            = MODE_NORMAL;
                end
            end
            MODE_EMIT_RD: begin
                // The buffer entry at rd_idx_reg is registered this cycle.
                mode_next = MODE_EMIT_WR;
            end
            MODE_EMIT_WR: begin
                if (out_free) begin
                    out_next            = seq_item;
                    out_next.char_value = cmd_reg;
                    out_next.arg_byte   = rd_data_reg;
                    out_next.last       = run_last;
                    out_valid_next      = 1'b1;
                    if (run_last) begin
                        mode_next = MODE_NORMAL;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        mode_next   = MODE_EMIT_RD;
                    end
                end
            end
            default: begin
                if (in_acc) begin
                    if (s_tdata == ESC_BYTE) begin
                        mode_next = MODE_ESCAPE;
                        meta_next = 1'b0;
                        fill_next = '0;
                        drop_next = 1'b0;
                    end else begin
                        out_next            = '0;
                        out_next.token_kind = KIND_CHAR;
                        out_next.char_value = s_tdata;
                        out_next.last       = 1'b1;
                        out_valid_next      = 1'b1;
                        mode_next           = MODE_NORMAL;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NORMAL;
            meta_reg      <= 1'b0;
            init_reg      <= '0;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            btn_reg       <= '0;
            xpos_reg      <= '0;
            rd_idx_reg    <= '0;
            sep_reg       <= SEP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            meta_reg      <= meta_next;
            init_reg      <= init_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            btn_reg       <= btn_next;
            xpos_reg      <= xpos_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                sep_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    // Argument buffer: written only while collecting; its registered read is used only during a run.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            arg_mem[fill_reg[IDX_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= arg_mem[rd_idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.token_kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.mouse_y, out_reg.mouse_x, out_reg.button_byte,
                       out_reg.arg_overflow, out_reg.arg_count, out_reg.arg_byte,
                       out_reg.initiator_byte, out_reg.meta_flag, out_reg.char_value};

endmodule

>>> sv/aesp_checker.sv
// ----------------------------------------------------------------------------
// Escape sequence parser checker
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aesp_checker
    import aesp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]  m_tuser,
    input logic               m_tlast,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    logic                      s_acc;
    logic                      m_stall;
    logic [TDATA_W+KIND_W:0]   m_word;

    assign s_acc   = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;
    assign m_word  = {m_tlast, m_tuser, m_tdata};

    `AESP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall,
        m_tvalid && $stable(m_word), "stalled result changed")

    `AESP_ASSERT_NOW(a_single_token, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_CHAR || m_tuser == KIND_MOUSE), m_tlast,
        "single token without end of run")

    `AESP_ASSERT_NOW(a_empty_seq, aclk, aresetn,
        m_tvalid && m_tuser == KIND_SEQ && m_tdata[29:25] == '0,
        m_tlast && m_tdata[24:17] == '0, "sequence without arguments is not a lone result")

    // While a result other than the last of its run waits, the run is still going.
    `AESP_ASSERT_NOW(a_run_blocks_input, aclk, aresetn, m_tvalid && !m_tlast, !s_acc,
        "byte taken inside a result run")

    `AESP_ASSERT_NOW(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready,
        "configuration port stalled")

endmodule

bind ansi_escape_sequence_parser aesp_checker u_aesp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
